// ===== rtl/core/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TRIG_TICKS   = 2'd0;
   localparam logic [1:0] CSR_GAP_TICKS    = 2'd1;
   localparam logic [1:0] CSR_TICKS_PER_CM = 2'd2;

   localparam logic [9:0]  TRIG_TICKS_RST   = 10'd20;
   localparam logic [19:0] GAP_TICKS_RST    = 20'd50000;
   localparam logic [7:0]  TICKS_PER_CM_RST = 8'd58;

   localparam int DIST_W = 20;

   // tick counter operations
   typedef logic [2:0] tick_op_type;
   localparam tick_op_type TK_HOLD   = 3'd0;
   localparam tick_op_type TK_INC    = 3'd1;
   localparam tick_op_type TK_SATINC = 3'd2;
   localparam tick_op_type TK_ZERO   = 3'd3;
   localparam tick_op_type TK_ONE    = 3'd4;

   typedef struct packed {
      logic        step;
      logic        restart;
      tick_op_type tick_op;
      logic        sum_add;
      logic        round_inc;
      logic        div_start;
      logic        div_step;
      logic        rsp_load;
      logic        rsp_trig;
      logic        rsp_busy;
      logic        rsp_done;
   } dp_cmd_type;

   typedef struct packed {
      logic trig_end;
      logic gap_end;
      logic last_round;
      logic div_last;
   } dp_status_type;

endpackage

// ===== rtl/core/uer_dpath.sv =====
// Datapath: config registers, tick/round/sum counters, divider and result register.
`timescale 1ns / 1ps

module uer_dpath #(
   parameter int READINGS  = 5,
   parameter int ECHO_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [1:0]               csr_index,
   input  logic [19:0]              csr_wdata,
   input  uer_pkg::dp_cmd_type      cmd,
   output uer_pkg::dp_status_type   status,
   output logic                     rsp_trig,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [uer_pkg::DIST_W-1:0] rsp_distance_q4
);

   localparam int TICK_W = (ECHO_BITS > 20) ? ECHO_BITS : 20;
   localparam int RND_W  = $clog2(READINGS + 1);
   localparam int SUM_W  = ECHO_BITS + $clog2(READINGS);
   localparam int NUM_W  = SUM_W + 4;
   localparam int DIV_W  = 8 + $clog2(READINGS + 1);
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int WIDE_W = (NUM_W > uer_pkg::DIST_W) ? NUM_W : uer_pkg::DIST_W;
   localparam logic [TICK_W-1:0] ECHO_MAX = TICK_W'({ECHO_BITS{1'b1}});
   localparam logic [WIDE_W-1:0] DIST_MAX = WIDE_W'({uer_pkg::DIST_W{1'b1}});

   logic [9:0]  trig_ticks_ff;
   logic [19:0] gap_ticks_ff;
   logic [7:0]  ticks_per_cm_ff;

   logic [TICK_W-1:0] tick_ff, tick_in, tick_base;
   logic [TICK_W:0]   tick_inc;
   logic [RND_W-1:0]  round_ff, round_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [9:0]        trig_len;

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W:0]    rem_shift;
   logic              quo_bit;
   logic [7:0]        tpc_eff;
   logic [WIDE_W-1:0] quo_ext;
   logic [uer_pkg::DIST_W-1:0] dist_sat;

   logic              trig_out_ff, busy_out_ff, done_out_ff;
   logic [uer_pkg::DIST_W-1:0] dist_out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ticks_ff   <= uer_pkg::TRIG_TICKS_RST;
         gap_ticks_ff    <= uer_pkg::GAP_TICKS_RST;
         ticks_per_cm_ff <= uer_pkg::TICKS_PER_CM_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            uer_pkg::CSR_TRIG_TICKS:   trig_ticks_ff   <= csr_wdata[9:0];
            uer_pkg::CSR_GAP_TICKS:    gap_ticks_ff    <= csr_wdata;
            uer_pkg::CSR_TICKS_PER_CM: ticks_per_cm_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // tick counter; a restart counts from zero
   assign tick_base = cmd.restart ? '0 : tick_ff;
   assign tick_inc  = {1'b0, tick_base} + (TICK_W+1)'(1);
   assign trig_len  = (trig_ticks_ff == 10'd0) ? 10'd1 : trig_ticks_ff;

   assign status.trig_end   = tick_inc >= (TICK_W+1)'(trig_len);
   assign status.gap_end    = tick_inc >= (TICK_W+1)'(gap_ticks_ff);
   assign status.last_round = round_ff >= RND_W'(READINGS);
   assign status.div_last   = cnt_ff == CNT_W'(NUM_W - 1);

   always_comb begin
      tick_in = tick_ff;
      case (cmd.tick_op)
         uer_pkg::TK_INC:    tick_in = tick_inc[TICK_W-1:0];
         uer_pkg::TK_SATINC: tick_in = (tick_ff < ECHO_MAX) ? tick_inc[TICK_W-1:0] : tick_ff;
         uer_pkg::TK_ZERO:   tick_in = '0;
         uer_pkg::TK_ONE:    tick_in = TICK_W'(1);
         default:            tick_in = tick_base;
      endcase
   end

   always_comb begin
      round_in = cmd.restart ? '0 : round_ff;
      sum_in   = cmd.restart ? '0 : sum_ff;
      if (cmd.round_inc) begin
         round_in = round_ff + RND_W'(1);
      end
      if (cmd.sum_add) begin
         sum_in = sum_ff + SUM_W'(tick_ff[ECHO_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         round_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.step) begin
         tick_ff  <= tick_in;
         round_ff <= round_in;
         sum_ff   <= sum_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign tpc_eff   = (ticks_per_cm_ff == 8'd0) ? 8'd1 : ticks_per_cm_ff;
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign quo_bit   = rem_shift >= {1'b0, dvsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      if (cmd.div_start) begin
         quo_in  = {sum_ff, 4'b0000};
         rem_in  = '0;
         dvsr_in = DIV_W'(32'(tpc_eff) * READINGS);
         cnt_in  = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[NUM_W-2:0], quo_bit};
         rem_in = quo_bit ? DIV_W'(rem_shift - {1'b0, dvsr_ff}) : rem_shift[DIV_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   // clamp the quotient to the result width
   assign quo_ext  = WIDE_W'(quo_ff);
   assign dist_sat = (quo_ext > DIST_MAX) ? '1 : quo_ext[uer_pkg::DIST_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         trig_out_ff <= cmd.rsp_trig;
         busy_out_ff <= cmd.rsp_busy;
         done_out_ff <= cmd.rsp_done;
         dist_out_ff <= cmd.rsp_done ? dist_sat : '0;
      end
   end

   assign rsp_trig        = trig_out_ff;
   assign rsp_busy_res    = busy_out_ff;
   assign rsp_done_res    = done_out_ff;
   assign rsp_distance_q4 = dist_out_ff;

endmodule

// ===== rtl/core/uer_ctrl.sv =====
// Controller: ranging phase machine, item handshake and divider sequencing.
`timescale 1ns / 1ps

module uer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_req,
   input  logic                   req_echo,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output uer_pkg::dp_cmd_type    cmd,
   input  uer_pkg::dp_status_type status
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_TRIG = 3'd1;
   localparam logic [2:0] PH_RISE = 3'd2;
   localparam logic [2:0] PH_HIGH = 3'd3;
   localparam logic [2:0] PH_GAP  = 3'd4;

   localparam logic [1:0] S_WAIT = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [2:0] phase_ff, phase_in, phase_eff;
   logic [1:0] seq_ff, seq_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       done;

   assign req_stall = (seq_ff != S_WAIT) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      phase_in  = phase_ff;
      seq_in    = seq_ff;
      phase_eff = phase_ff;
      done      = 1'b0;

      unique case (seq_ff)
         S_WAIT: begin
            if (accept) begin
               cmd.step = 1'b1;
               if (phase_ff == PH_IDLE && req_start_req) begin
                  cmd.restart = 1'b1;
                  phase_eff   = PH_TRIG;
               end
               phase_in = phase_eff;
               unique case (phase_eff)
                  PH_TRIG: begin
                     cmd.rsp_trig = 1'b1;
                     if (status.trig_end) begin
                        cmd.tick_op = uer_pkg::TK_ZERO;
                        phase_in    = PH_RISE;
                     end else begin
                        cmd.tick_op = uer_pkg::TK_INC;
                     end
                  end
                  PH_RISE: begin
                     if (req_echo) begin
                        cmd.tick_op = uer_pkg::TK_ONE;
                        phase_in    = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     if (req_echo) begin
                        cmd.tick_op = uer_pkg::TK_SATINC;
                     end else begin
                        cmd.tick_op   = uer_pkg::TK_ZERO;
                        cmd.sum_add   = 1'b1;
                        cmd.round_inc = 1'b1;
                        phase_in      = PH_GAP;
                     end
                  end
                  PH_GAP: begin
                     if (status.gap_end) begin
                        cmd.tick_op = uer_pkg::TK_ZERO;
                        if (status.last_round) begin
                           done     = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           phase_in = PH_TRIG;
                        end
                     end else begin
                        cmd.tick_op = uer_pkg::TK_INC;
                     end
                  end
                  default: ;
               endcase
               // the averaging item waits for the divider
               if (done) begin
                  cmd.div_start = 1'b1;
                  seq_in        = S_DIV;
               end else begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_busy = phase_in != PH_IDLE;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               seq_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_done = 1'b1;
            seq_in       = S_WAIT;
         end
         default: seq_in = S_WAIT;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seq_ff       <= S_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_top.sv =====
// Top level of the ultrasonic echo ranger: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_start_req, req_echo
//   rsp     | out       | rsp_valid / rsp_stall | rsp_trig, rsp_busy_res, rsp_done_res,
//           |           |                       | rsp_distance_q4
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One tick item per cycle; each result sits in an output register, so the
// next item is taken while the previous result waits, unless that result is stalled.
// The averaging item holds req stalled while the restoring divider produces
// one quotient bit per cycle and then loads the result.
// Reset is synchronous but skips the divider and result registers; csr is always ready.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_top #(
   parameter int READINGS  = 5,
   parameter int ECHO_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_start_req,
   input  logic        req_echo,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trig,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [19:0] rsp_distance_q4,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   uer_pkg::dp_cmd_type    cmd;
   uer_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   uer_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_echo      (req_echo),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   uer_dpath #(
      .READINGS  (READINGS),
      .ECHO_BITS (ECHO_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_trig        (rsp_trig),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_distance_q4 (rsp_distance_q4)
   );

   // a finished average ends the sequence with the trigger low
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (!rsp_busy_res && !rsp_trig))
      else $error("done item with busy or trigger set");

   // distance is zero except on the done item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_done_res) |-> (rsp_distance_q4 == 20'd0))
      else $error("distance nonzero without done");

   // an item is taken only when the result register can accept its result
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> (!rsp_valid || !rsp_stall))
      else $error("input open while result register is blocked");

endmodule

// ===== verif/tb_ultrasonic_echo_ranger_top.sv =====
// Self-checking testbench for the ultrasonic echo ranger top level.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_top;

   localparam int READINGS = 5;
   localparam int ECHO_BITS = 16;
   localparam int DIST_W = uer_pkg::DIST_W;
   localparam int unsigned ECHO_MAX = (32'd1 << ECHO_BITS) - 1;
   localparam int unsigned DIST_MAX = 32'hFFFFF;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int NO_LIMIT = 32'h7FFFFFFF;
   localparam int CHUNK_TICKS = 150;

   typedef enum logic [2:0] {
      RG_IDLE = 3'd0,
      RG_TRIG = 3'd1,
      RG_RISE = 3'd2,
      RG_HIGH = 3'd3,
      RG_GAP  = 3'd4
   } ranger_phase_type;

   typedef enum logic [1:0] {
      IDLE_SLOW_RSP,
      IDLE_SLOW_REQ,
      IDLE_NONE
   } idle_mode_type;

   typedef struct {
      logic              trig;
      logic              busy;
      logic              done;
      logic [DIST_W-1:0] distance;
   } reading_type;

   class echo_range_checker;
      ranger_phase_type ph;
      logic [19:0]      tick_cnt;
      logic [4:0]       rounds;
      logic [18:0]      echo_sum;
      logic [9:0]       trig_len;
      logic [19:0]      gap_len;
      logic [7:0]       cm_ticks;
      reading_type      expected_readings[$];
      int               failures;
      int               readings_seen;

      function new();
         ph = RG_IDLE;
         tick_cnt = '0;
         rounds = '0;
         echo_sum = '0;
         trig_len = uer_pkg::TRIG_TICKS_RST;
         gap_len = uer_pkg::GAP_TICKS_RST;
         cm_ticks = uer_pkg::TICKS_PER_CM_RST;
         failures = 0;
         readings_seen = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [19:0] data);
         case (idx)
            uer_pkg::CSR_TRIG_TICKS:   trig_len = data[9:0];
            uer_pkg::CSR_GAP_TICKS:    gap_len = data;
            uer_pkg::CSR_TICKS_PER_CM: cm_ticks = data[7:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      // advance the shadow sequencer by one tick and queue its reading
      function void take_tick(logic start, logic echo);
         reading_type r;
         logic [9:0]  len;
         int unsigned divisor;
         int unsigned q;
         r.trig = 1'b0;
         r.done = 1'b0;
         r.distance = '0;
         if (ph == RG_IDLE && start) begin
            ph = RG_TRIG;
            tick_cnt = '0;
            rounds = '0;
            echo_sum = '0;
         end
         case (ph)
            RG_TRIG: begin
               len = (trig_len == 0) ? 10'd1 : trig_len;
               r.trig = 1'b1;
               tick_cnt++;
               if (tick_cnt >= len) begin
                  ph = RG_RISE;
                  tick_cnt = '0;
               end
            end
            RG_RISE: begin
               if (echo) begin
                  ph = RG_HIGH;
                  tick_cnt = 20'd1;
               end
            end
            RG_HIGH: begin
               if (echo) begin
                  if (tick_cnt < ECHO_MAX) tick_cnt++;
               end else begin
                  echo_sum += 19'(tick_cnt);
                  rounds++;
                  ph = RG_GAP;
                  tick_cnt = '0;
               end
            end
            RG_GAP: begin
               tick_cnt++;
               if (tick_cnt >= gap_len) begin
                  tick_cnt = '0;
                  if (rounds >= READINGS) begin
                     divisor = ((cm_ticks == 0) ? 1 : cm_ticks) * READINGS;
                     q = (int'(echo_sum) * 16) / divisor;
                     r.distance = (q > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(q);
                     r.done = 1'b1;
                     ph = RG_IDLE;
                  end else begin
                     ph = RG_TRIG;
                  end
               end
            end
            default: ;
         endcase
         r.busy = (ph != RG_IDLE);
         expected_readings.push_back(r);
      endfunction

      function void check_reading(logic trig, logic busy, logic done,
                                  logic [DIST_W-1:0] distance);
         reading_type r;
         readings_seen++;
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("reading %0d arrived with no tick pending", readings_seen);
            return;
         end
         r = expected_readings.pop_front();
         if (trig !== r.trig || busy !== r.busy || done !== r.done ||
             distance !== r.distance) begin
            failures++;
            if (failures <= 10)
               $display({"reading %0d: trig %0b/%0b busy %0b/%0b done %0b/%0b",
                         " distance %0d/%0d (exp/got)"},
                        readings_seen, r.trig, trig, r.busy, busy, r.done, done,
                        r.distance, distance);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_start_req;
   logic              req_echo;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_trig;
   logic              rsp_busy_res;
   logic              rsp_done_res;
   logic [19:0]       rsp_distance_q4;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [19:0]       csr_wdata;

   echo_range_checker chk = new();
   int                snd_idle_pct;
   int                rcv_idle_pct;
   int                holdoffs_wanted = 0;
   int                holdoffs_done = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;
   logic              progress;

   ultrasonic_echo_ranger_top #(
      .READINGS(READINGS),
      .ECHO_BITS(ECHO_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_req(req_start_req),
      .req_echo(req_echo),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_trig(rsp_trig),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_distance_q4(rsp_distance_q4),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random stall, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holdoffs_wanted != holdoffs_done) begin
         holdoffs_done++;
         hold_left = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // sample handshakes mid-cycle, where nothing is changing
   always @(negedge clock) begin
      if (!reset) begin
         progress = (req_valid && !req_stall) || (csr_valid && csr_ready);
         if (rsp_valid && !rsp_stall) begin
            progress = 1'b1;
            chk.check_reading(rsp_trig, rsp_busy_res, rsp_done_res, rsp_distance_q4);
         end
         if (progress) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ultrasonic_echo_ranger_top: mismatch");
            $finish;
         end
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_SLOW_RSP: begin
            snd_idle_pct = 27;
            rcv_idle_pct = 88;
         end
         IDLE_SLOW_REQ: begin
            snd_idle_pct = 88;
            rcv_idle_pct = 27;
         end
         default: begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic send_tick(logic s, logic e);
      logic took;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_req <= s;
      req_echo <= e;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      chk.take_tick(s, e);
   endtask

   // wait out every pending reading and the divider tail
   task automatic drain();
      req_valid <= 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [19:0] data);
      logic took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
      chk.set_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [9:0] trig, logic [19:0] gap, logic [7:0] cm);
      csr_write(uer_pkg::CSR_TRIG_TICKS, {10'd0, trig});
      csr_write(uer_pkg::CSR_GAP_TICKS, gap);
      csr_write(uer_pkg::CSR_TICKS_PER_CM, {12'd0, cm});
   endtask

   // one well-formed measurement with a fixed echo shape; keep requesting start while busy
   task automatic measure(int rise_wait, int first_high, int high_len, int limit);
      int   sent;
      int   waited;
      int   highs;
      logic e;
      sent = 0;
      waited = 0;
      highs = 0;
      do begin
         e = 1'b0;
         case (chk.ph)
            RG_IDLE, RG_TRIG: begin
               waited = 0;
               highs = 0;
               e = 1'($urandom_range(1));
            end
            RG_RISE: begin
               if (waited >= rise_wait) begin
                  e = 1'b1;
                  highs = 1;
               end else begin
                  waited++;
               end
            end
            RG_HIGH: begin
               e = highs < ((chk.rounds == 0) ? first_high : high_len);
               if (e) highs++;
            end
            default: e = 1'($urandom_range(1));
         endcase
         send_tick(1'b1, e);
         sent++;
      end while (chk.ph != RG_IDLE && sent < limit);
   endtask

   task automatic random_chunk(int n, logic with_holdoff);
      int   rise_pct;
      int   stay_pct;
      logic s;
      logic e;
      drain();
      write_all(10'($urandom_range(0, 6)), 20'($urandom_range(0, 10)),
                8'($urandom_range(0, 255)));
      rise_pct = $urandom_range(20, 70);
      stay_pct = $urandom_range(40, 95);
      if (with_holdoff) holdoffs_wanted++;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) begin
            s = 1'($urandom_range(1));
            e = 1'($urandom_range(1));
         end else begin
            case (chk.ph)
               RG_IDLE: begin
                  s = ($urandom_range(99) < 80);
                  e = ($urandom_range(99) < 10);
               end
               RG_RISE: begin
                  s = ($urandom_range(99) < 15);
                  e = ($urandom_range(99) < rise_pct);
               end
               RG_HIGH: begin
                  s = ($urandom_range(99) < 15);
                  e = ($urandom_range(99) < stay_pct);
               end
               default: begin
                  s = ($urandom_range(99) < 15);
                  e = ($urandom_range(99) < 15);
               end
            endcase
         end
         send_tick(s, e);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_start_req = 1'b0;
      req_echo = 1'b0;
      csr_valid = 1'b0;
      csr_index = uer_pkg::CSR_TRIG_TICKS;
      csr_wdata = '0;
      set_idling(IDLE_SLOW_RSP);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // idle ticks under the reset settings
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();

      // zero trigger length and zero divisor, shortest echo
      write_all(10'd0, 20'd0, 8'd0);
      measure(0, 1, 1, NO_LIMIT);
      drain();

      // echo held low for a while before rising
      write_all(10'd1, 20'd2, 8'd1);
      measure(20, 9, 3, NO_LIMIT);
      drain();

      // long trigger, longest gap cut short by a rewrite mid-pause
      write_all(10'd300, 20'hFFFFF, 8'd255);
      measure(2, 4, 4, 320);
      drain();
      csr_write(uer_pkg::CSR_TRIG_TICKS, 20'd3);
      csr_write(uer_pkg::CSR_GAP_TICKS, 20'd7);
      measure(1, 5, 5, NO_LIMIT);

      random_chunk(CHUNK_TICKS, 1'b0);
      random_chunk(CHUNK_TICKS, 1'b0);
      set_idling(IDLE_SLOW_REQ);
      random_chunk(CHUNK_TICKS, 1'b0);
      random_chunk(CHUNK_TICKS, 1'b0);
      set_idling(IDLE_NONE);

      // long echo in the first round
      drain();
      write_all(10'd1, 20'd0, 8'd1);
      measure(0, 200, 2, NO_LIMIT);

      random_chunk(CHUNK_TICKS, 1'b1);
      random_chunk(CHUNK_TICKS, 1'b0);
      drain();

      if (chk.failures == 0 && chk.pending() == 0) begin
         $display("ultrasonic_echo_ranger_top: match");
      end else begin
         $display("ultrasonic_echo_ranger_top: mismatch");
      end
      $finish;
   end

endmodule
